/* rtl/tcpq_pkg.sv */
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

    // Width of the capacity register and of the entry counters.
    localparam int CAP_BITS = 7;

    // Width of the message handle on the ports.
    localparam int PAY_W = 16;

    // Capacity after reset.
    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 7'd64;

    // Operation codes.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic             op;
        logic [PAY_W-1:0] payload;
        logic             low_priority;
    } in_item_t;

    typedef struct packed {
        logic                accepted;
        logic                out_valid;
        logic [PAY_W-1:0]    out_payload;
        logic                out_low_priority;
        logic [CAP_BITS-1:0] occupancy;
    } result_t;

endpackage

/* rtl/two_class_priority_queue.sv */
// Top level of the two-class strict-priority message queue.
//
// The queue holds message handles in two FIFOs, one for high-priority
// messages and one for low-priority (sensor) messages, each kept in its own
// single-port-write, registered-read RAM of DEPTH entries. Every input
// transaction is either an enqueue or a dequeue and produces exactly one
// result transaction. An enqueue stores the handle in the FIFO of its class
// unless the total held across both classes has reached the capacity
// register (clamped to DEPTH), in which case it reports accepted = 0. A
// dequeue returns the oldest high-priority entry if there is one, otherwise
// the oldest sensor entry, or out_valid = 0 when both FIFOs are empty.
// Every result carries the occupancy after the operation. An enqueue or an
// empty dequeue produces its result at once; a dequeue that returns an
// entry waits for the registered RAM read data, and the next input
// transaction waits for it. Results go into a two-entry buffer, so the block
// keeps taking input transactions while up to one earlier result waits on
// the result channel. The RAMs need no clearing after reset: only entries
// that were written are ever read. The capacity register is written through
// the configuration channel, which is always ready.
module two_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_BITS-1:0] cfg_data
);

    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int STORE_BITS = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int CAP_MAX    = (1 << CAP_BITS) - 1;
    localparam int LIMIT_MAX  = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
    localparam logic [CAP_BITS-1:0] LIMIT_MAX_C = CAP_BITS'(LIMIT_MAX);
    localparam logic [PTR_BITS-1:0] LAST_SLOT   = PTR_BITS'(DEPTH - 1);

    // Controller states: idle, or waiting for the registered RAM read data.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                state_reg, state_next;
    logic [CAP_BITS-1:0] capacity_reg;
    logic [PTR_BITS-1:0] high_head_reg, high_head_next;
    logic [PTR_BITS-1:0] high_tail_reg, high_tail_next;
    logic [PTR_BITS-1:0] low_head_reg, low_head_next;
    logic [PTR_BITS-1:0] low_tail_reg, low_tail_next;
    logic [CAP_BITS-1:0] high_count_reg, high_count_next;
    logic [CAP_BITS-1:0] low_count_reg, low_count_next;
    logic                sel_low_reg, sel_low_next;
    logic [CAP_BITS-1:0] occ_reg, occ_next;

    logic                accept;
    logic                is_enq;
    logic                is_deq;
    logic                enq_ok;
    logic                enq_high;
    logic                enq_low;
    logic                deq_high;
    logic                deq_low;
    logic                deq_empty;
    logic [CAP_BITS-1:0] limit;
    logic [CAP_BITS:0]   total;
    logic [CAP_BITS-1:0] total_after_enq;

    logic                buf_full;
    logic                push;
    result_t             push_data;

    logic [STORE_BITS-1:0] store_wdata;
    logic [STORE_BITS-1:0] high_rdata;
    logic [STORE_BITS-1:0] low_rdata;
    logic [STORE_BITS-1:0] sel_rdata;

    function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + PTR_BITS'(1);
    endfunction

    // The configuration channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // A new transaction is taken only when the controller is idle and the
    // result buffer has room for its result.
    assign in_ready = (state_reg == ST_IDLE) && !buf_full;
    assign accept   = in_valid && in_ready;
    assign is_enq   = accept && (in_data.op == OP_ENQ);
    assign is_deq   = accept && (in_data.op == OP_DEQ);

    // Capacity above the RAM depth behaves as the depth.
    assign limit = (capacity_reg > LIMIT_MAX_C) ? LIMIT_MAX_C : capacity_reg;
    assign total = {1'b0, high_count_reg} + {1'b0, low_count_reg};

    assign enq_ok    = is_enq && (total < {1'b0, limit});
    assign enq_high  = enq_ok && !in_data.low_priority;
    assign enq_low   = enq_ok && in_data.low_priority;
    assign deq_high  = is_deq && (high_count_reg != '0);
    assign deq_low   = is_deq && (high_count_reg == '0) && (low_count_reg != '0);
    assign deq_empty = is_deq && (high_count_reg == '0) && (low_count_reg == '0);

    assign total_after_enq = enq_ok ? total[CAP_BITS-1:0] + CAP_BITS'(1)
                                    : total[CAP_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        high_head_next  = high_head_reg;
        high_tail_next  = high_tail_reg;
        low_head_next   = low_head_reg;
        low_tail_next   = low_tail_reg;
        high_count_next = high_count_reg;
        low_count_next  = low_count_reg;
        sel_low_next    = sel_low_reg;
        occ_next        = occ_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (enq_high)
                begin
                    high_tail_next  = next_slot(high_tail_reg);
                    high_count_next = high_count_reg + CAP_BITS'(1);
                end
                if (enq_low)
                begin
                    low_tail_next  = next_slot(low_tail_reg);
                    low_count_next = low_count_reg + CAP_BITS'(1);
                end
                if (deq_high)
                begin
                    high_head_next  = next_slot(high_head_reg);
                    high_count_next = high_count_reg - CAP_BITS'(1);
                end
                if (deq_low)
                begin
                    low_head_next  = next_slot(low_head_reg);
                    low_count_next = low_count_reg - CAP_BITS'(1);
                end
                if (deq_high || deq_low)
                begin
                    // Remember the class and the occupancy for the cycle in
                    // which the read data comes back.
                    sel_low_next = deq_low;
                    occ_next     = total[CAP_BITS-1:0] - CAP_BITS'(1);
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            high_head_reg  <= '0;
            high_tail_reg  <= '0;
            low_head_reg   <= '0;
            low_tail_reg   <= '0;
            high_count_reg <= '0;
            low_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            high_head_reg  <= high_head_next;
            high_tail_reg  <= high_tail_next;
            low_head_reg   <= low_head_next;
            low_tail_reg   <= low_tail_next;
            high_count_reg <= high_count_next;
            low_count_reg  <= low_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_low_reg <= sel_low_next;
        occ_reg     <= occ_next;
    end

    // When PAYLOAD_BITS is narrower than the port, handles drop their upper bits when stored.
    assign store_wdata = in_data.payload[STORE_BITS-1:0];

    tcpq_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (DEPTH)
    ) u_high_ram (
        .clk   (clk),
        .we    (enq_high),
        .waddr (high_tail_reg),
        .wdata (store_wdata),
        .re    (deq_high),
        .raddr (high_head_reg),
        .rdata (high_rdata)
    );

    tcpq_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (DEPTH)
    ) u_low_ram (
        .clk   (clk),
        .we    (enq_low),
        .waddr (low_tail_reg),
        .wdata (store_wdata),
        .re    (deq_low),
        .raddr (low_head_reg),
        .rdata (low_rdata)
    );

    assign sel_rdata = sel_low_reg ? low_rdata : high_rdata;

    // Enqueues and empty dequeues produce their result at once; a dequeue
    // that found an entry produces it in the following cycle from the RAM data.
    always_comb
    begin
        push                       = 1'b0;
        push_data.accepted         = 1'b0;
        push_data.out_valid        = 1'b0;
        push_data.out_payload      = '0;
        push_data.out_low_priority = 1'b0;
        push_data.occupancy        = total[CAP_BITS-1:0];
        if (state_reg == ST_READ)
        begin
            push                       = 1'b1;
            push_data.out_valid        = 1'b1;
            push_data.out_payload      = PAY_W'(sel_rdata);
            push_data.out_low_priority = sel_low_reg;
            push_data.occupancy        = occ_reg;
        end
        else if (is_enq || deq_empty)
        begin
            push                = 1'b1;
            push_data.accepted  = enq_ok;
            push_data.occupancy = total_after_enq;
        end
    end

    tcpq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // The entries held never exceed what the RAMs and the register allow.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total <= (CAP_BITS + 1)'(LIMIT_MAX))
        else $error("occupancy above limit");

    // The read wait state is always followed by idle in the next cycle.
    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_IDLE)
        else $error("read wait longer than one cycle");

    // A dequeue that finds an entry leaves one entry fewer.
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (deq_high || deq_low) |=> total == $past(total) - (CAP_BITS + 1)'(1))
        else $error("dequeue count mismatch");

endmodule

/* rtl/tcpq_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module tcpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcpq_obuf.sv */
// Two-entry result buffer that decouples the queue logic from the result channel.
module tcpq_obuf
    import tcpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_data
);

    logic    v0_reg, v0_next;
    logic    v1_reg, v1_next;
    result_t d0_reg, d0_next;
    result_t d1_reg, d1_next;
    logic    pop;

    assign pop = v0_reg && res_ready;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (pop)
        begin
            v0_next = v1_reg;
            d0_next = d1_reg;
            v1_next = 1'b0;
        end
        if (push)
        begin
            if (!v0_next)
            begin
                v0_next = 1'b1;
                d0_next = push_data;
            end
            else
            begin
                v1_next = 1'b1;
                d1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign full      = v1_reg;
    assign res_valid = v0_reg;
    assign res_data  = d0_reg;

    // A result must never arrive while both entries are held and none leaves.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && v1_reg |-> pop)
        else $error("result buffer overflow");

endmodule
